// ===== rtl/sfs_pkg.sv =====
// ---------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer: operation codes,
// register indexes, sequencer states and the structs passed between modules.
// ---------------------------------------------------------------------------
package sfs_pkg;

   // duration table geometry, fixed by the 4-bit entry and frame fields
   localparam int FRAME_SLOTS = 16;
   localparam int FRAME_W     = 4;
   localparam int DUR_W       = 16;
   localparam int POS_W       = 17;
   localparam int COUNT_W     = 5;
   localparam int SPEED_W     = 16;
   localparam int FNUM_W      = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // reset values of the control registers
   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 5'd1;
   localparam logic               LOOP_RESET        = 1'b0;
   localparam logic [SPEED_W-1:0] SPEED_RESET       = 16'd256;

   // operation codes of a request transaction
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_WRITE_DUR = 2'd1,
      OP_RESTART   = 2'd2,
      OP_SET_FRAME = 2'd3
   } op_type;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED       = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_STEP,
      S_REPLY
   } state_type;

   // control register set as seen by the engine
   typedef struct packed {
      logic [COUNT_W-1:0] frame_count;
      logic               loop_enable;
      logic [SPEED_W-1:0] speed;
   } cfg_type;

   // result of one transaction
   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               completed;
      logic               active;
      logic [POS_W-1:0]   position;
   } rsp_type;

   // write port of the duration table
   typedef struct packed {
      logic               en;
      logic [FRAME_W-1:0] addr;
      logic [DUR_W-1:0]   data;
   } dur_wr_type;

endpackage

// ===== rtl/sfs_dur_ram.sv =====
// ---------------------------------------------------------------------------
// sfs_dur_ram
// Frame duration table: one write port and one read port, read data
// registered, read before write on the same address.
// ---------------------------------------------------------------------------
module sfs_dur_ram (
   input  logic                             clock,
   input  sfs_pkg::dur_wr_type              wr,
   input  logic [sfs_pkg::FRAME_W-1:0]      rd_addr,
   output logic [sfs_pkg::DUR_W-1:0]        rd_data
);

   logic [sfs_pkg::DUR_W-1:0] dur_mem_ff [sfs_pkg::FRAME_SLOTS];
   logic [sfs_pkg::DUR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         dur_mem_ff[wr.addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= dur_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfs_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// sfs_rsp_reg
// Output register of the result channel: holds one finished result until the
// receiver takes it, and tells the engine when it can take a new one.
// ---------------------------------------------------------------------------
module sfs_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sfs_pkg::rsp_type load_data,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfs_pkg::rsp_type rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   sfs_pkg::rsp_type data_ff;

   // slot is free when empty or being drained this cycle
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/sfs_engine.sv =====
// ---------------------------------------------------------------------------
// sfs_engine
// Sequencer of the frame stepper: holds position, frame and flags, decodes
// each transaction and walks the duration table one entry per cycle on a tick.
// ---------------------------------------------------------------------------
module sfs_engine #(
   parameter int MAX_ADVANCE = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfs_pkg::cfg_type                cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [sfs_pkg::FRAME_W-1:0]     req_entry_index,
   input  logic [sfs_pkg::DUR_W-1:0]       req_duration,
   input  logic signed [sfs_pkg::FNUM_W-1:0] req_frame_number,
   input  logic                            req_overwrite,
   output sfs_pkg::dur_wr_type             dur_wr,
   output logic [sfs_pkg::FRAME_W-1:0]     dur_rd_addr,
   input  logic [sfs_pkg::DUR_W-1:0]       dur_rd_data,
   input  logic                            rsp_free,
   output logic                            rsp_load,
   output sfs_pkg::rsp_type                rsp_data
);

   localparam int ADV_W = $clog2(MAX_ADVANCE + 1);
   localparam logic [ADV_W-1:0] ADV_LIMIT = ADV_W'(MAX_ADVANCE);

   sfs_pkg::state_type              state_ff, state_in;
   logic [sfs_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [sfs_pkg::FRAME_W-1:0]     frame_ff, frame_in;
   logic                            done_ff, done_in;
   logic                            active_ff, active_in;
   logic [ADV_W-1:0]                adv_ff, adv_in;

   // latched request payload
   sfs_pkg::op_type                 op_ff;
   logic [sfs_pkg::FRAME_W-1:0]     idx_ff;
   logic [sfs_pkg::DUR_W-1:0]       dur_ff;
   logic signed [sfs_pkg::FNUM_W-1:0] fnum_ff;
   logic                            ovw_ff;

   logic                            accept;
   logic [sfs_pkg::COUNT_W-1:0]     cnt_eff;
   logic [sfs_pkg::FRAME_W-1:0]     cnt_last;
   logic [sfs_pkg::POS_W:0]         pos_sum;
   logic [sfs_pkg::POS_W-1:0]       dur_eff;
   logic                            reach;
   logic [sfs_pkg::COUNT_W-1:0]     frame_next;
   logic [sfs_pkg::FRAME_W-1:0]     frame_clamp;

   assign accept = req_valid && req_ready;

   // effective frame count, clamped into 1..FRAME_SLOTS
   always_comb begin
      if (cfg.frame_count == '0) begin
         cnt_eff = sfs_pkg::COUNT_W'(1);
      end else if (cfg.frame_count > sfs_pkg::COUNT_W'(sfs_pkg::FRAME_SLOTS)) begin
         cnt_eff = sfs_pkg::COUNT_W'(sfs_pkg::FRAME_SLOTS);
      end else begin
         cnt_eff = cfg.frame_count;
      end
   end
   assign cnt_last = sfs_pkg::FRAME_W'(cnt_eff - sfs_pkg::COUNT_W'(1));

   // tick arithmetic: speed add, zero duration counts as one lsb
   assign pos_sum    = {1'b0, pos_ff} + {{(sfs_pkg::POS_W + 1 - sfs_pkg::SPEED_W){1'b0}},
                                         cfg.speed};
   assign dur_eff    = (dur_rd_data == '0) ? sfs_pkg::POS_W'(1) : {1'b0, dur_rd_data};
   assign reach      = pos_ff >= dur_eff;
   assign frame_next = {1'b0, frame_ff} + sfs_pkg::COUNT_W'(1);

   // set-frame clamp of the signed request
   always_comb begin
      if (fnum_ff[sfs_pkg::FNUM_W-1]) begin
         frame_clamp = '0;
      end else if (fnum_ff >= $signed({{(sfs_pkg::FNUM_W - sfs_pkg::COUNT_W){1'b0}},
                                       cnt_eff})) begin
         frame_clamp = cnt_last;
      end else begin
         frame_clamp = fnum_ff[sfs_pkg::FRAME_W-1:0];
      end
   end

   // state register and animation state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sfs_pkg::S_IDLE;
         pos_ff    <= '0;
         frame_ff  <= '0;
         done_ff   <= 1'b0;
         active_ff <= 1'b0;
         adv_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         frame_ff  <= frame_in;
         done_ff   <= done_in;
         active_ff <= active_in;
         adv_ff    <= adv_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= sfs_pkg::op_type'(req_op);
         idx_ff  <= req_entry_index;
         dur_ff  <= req_duration;
         fnum_ff <= req_frame_number;
         ovw_ff  <= req_overwrite;
      end
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      frame_in    = frame_ff;
      done_in     = done_ff;
      active_in   = active_ff;
      adv_in      = adv_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      dur_wr.en   = 1'b0;
      dur_wr.addr = idx_ff;
      dur_wr.data = dur_ff;

      case (state_ff)
         sfs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = sfs_pkg::S_EXEC;
            end
         end

         sfs_pkg::S_EXEC: begin
            state_in = sfs_pkg::S_REPLY;
            case (op_ff)
               sfs_pkg::OP_TICK: begin
                  if (active_ff) begin
                     pos_in   = pos_sum[sfs_pkg::POS_W-1:0];
                     adv_in   = '0;
                     state_in = sfs_pkg::S_STEP;
                  end
               end
               sfs_pkg::OP_WRITE_DUR: begin
                  dur_wr.en = 1'b1;
               end
               sfs_pkg::OP_RESTART: begin
                  if (ovw_ff || !active_ff) begin
                     active_in = 1'b1;
                     frame_in  = '0;
                     pos_in    = '0;
                     done_in   = 1'b0;
                  end
               end
               sfs_pkg::OP_SET_FRAME: begin
                  frame_in = frame_clamp;
                  pos_in   = '0;
               end
               default: begin
                  state_in = sfs_pkg::S_REPLY;
               end
            endcase
         end

         // one table entry per cycle; read data belongs to frame_ff
         sfs_pkg::S_STEP: begin
            if (adv_ff == ADV_LIMIT) begin
               if (reach) begin
                  pos_in = '0;
               end
               state_in = sfs_pkg::S_REPLY;
            end else if (!reach) begin
               state_in = sfs_pkg::S_REPLY;
            end else begin
               pos_in = pos_ff - dur_eff;
               adv_in = adv_ff + ADV_W'(1);
               if (frame_next >= cnt_eff) begin
                  done_in  = 1'b1;
                  frame_in = cfg.loop_enable ? '0 : cnt_last;
               end else begin
                  frame_in = frame_next[sfs_pkg::FRAME_W-1:0];
               end
            end
         end

         sfs_pkg::S_REPLY: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = sfs_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sfs_pkg::S_IDLE;
         end
      endcase
   end

   // read address follows the next frame so data is ready in the next cycle
   assign dur_rd_addr = frame_in;

   assign rsp_data.frame_index = frame_ff;
   assign rsp_data.completed   = done_ff;
   assign rsp_data.active      = active_ff;
   assign rsp_data.position    = pos_ff;

endmodule

// ===== rtl/sprite_frame_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// sprite_frame_sequencer_top
// Animation frame sequencer: steps a frame index through a table of Q8.8
// frame durations, one tick transaction per video frame.
//
// Request channel (req_*): op 0 tick, 1 write a duration entry, 2 restart,
// 3 set frame. Every request transaction yields exactly one result
// transaction on the rsp_* channel with frame, flags and position after it.
// Control registers (csr_*) are written with a single-cycle write enable:
// index 0 frame count, 1 loop enable, 2 speed. Write them only while idle.
// Order: an accepted request passes through an execute state and a reply
// state, which loads the result into the output register; a tick while
// active walks a step state in between, advancing up to MAX_ADVANCE frames.
// The engine takes the next request once back in idle after the load, and
// takes none while a request is in work. The tick walk reads one duration
// entry per cycle from the table memory.
// A finished result waits in the output register while the receiver stalls;
// the next request is already taken and worked on, and holds only if its own
// result finds the register still full.
// Reset clears position, frame and flags and loads the register defaults;
// the duration table is not cleared and must be written before use.
// ---------------------------------------------------------------------------
module sprite_frame_sequencer_top #(
   parameter int MAX_ADVANCE = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_op,
   input  logic [sfs_pkg::FRAME_W-1:0]          req_entry_index,
   input  logic [sfs_pkg::DUR_W-1:0]            req_duration,
   input  logic signed [sfs_pkg::FNUM_W-1:0]    req_frame_number,
   input  logic                                 req_overwrite,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sfs_pkg::FRAME_W-1:0]          rsp_frame_index,
   output logic                                 rsp_completed,
   output logic                                 rsp_active,
   output logic [sfs_pkg::POS_W-1:0]            rsp_position_out,
   input  logic                                 csr_write_enable,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   sfs_pkg::cfg_type    cfg_ff;
   sfs_pkg::dur_wr_type dur_wr;
   logic [sfs_pkg::FRAME_W-1:0] dur_rd_addr;
   logic [sfs_pkg::DUR_W-1:0]   dur_rd_data;
   logic                rsp_free;
   logic                rsp_load;
   sfs_pkg::rsp_type    rsp_next;
   sfs_pkg::rsp_type    rsp_out;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count <= sfs_pkg::FRAME_COUNT_RESET;
         cfg_ff.loop_enable <= sfs_pkg::LOOP_RESET;
         cfg_ff.speed       <= sfs_pkg::SPEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfs_pkg::CSR_FRAME_COUNT: begin
               cfg_ff.frame_count <= csr_write_data[sfs_pkg::COUNT_W-1:0];
            end
            sfs_pkg::CSR_LOOP_ENABLE: begin
               cfg_ff.loop_enable <= csr_write_data[0];
            end
            sfs_pkg::CSR_SPEED: begin
               cfg_ff.speed <= csr_write_data[sfs_pkg::SPEED_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // sequencer
   sfs_engine #(
      .MAX_ADVANCE (MAX_ADVANCE)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_duration     (req_duration),
      .req_frame_number (req_frame_number),
      .req_overwrite    (req_overwrite),
      .dur_wr           (dur_wr),
      .dur_rd_addr      (dur_rd_addr),
      .dur_rd_data      (dur_rd_data),
      .rsp_free         (rsp_free),
      .rsp_load         (rsp_load),
      .rsp_data         (rsp_next)
   );

   // duration table
   sfs_dur_ram u_dur_ram (
      .clock   (clock),
      .wr      (dur_wr),
      .rd_addr (dur_rd_addr),
      .rd_data (dur_rd_data)
   );

   // result output register
   sfs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_out)
   );

   assign rsp_frame_index  = rsp_out.frame_index;
   assign rsp_completed    = rsp_out.completed;
   assign rsp_active       = rsp_out.active;
   assign rsp_position_out = rsp_out.position;

endmodule

// ===== bench/sprite_frame_sequencer_top_tb.sv =====
// ---------------------------------------------------------------------------
// sprite_frame_sequencer_top_tb
// Self-checking bench for the animation frame sequencer. A behavioural copy
// of the sequencer predicts the frame, flags and position after every request
// transaction; each result transaction is checked field by field against the
// oldest prediction. Directed tests cover the inactive state, table loading,
// restarts, set-frame clamping, zero durations, the advance cap and a shrunk
// frame count, followed by randomised phases over several register settings
// with random gaps on the request side and stalls on the result side.
// ---------------------------------------------------------------------------
module sprite_frame_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADVANCE_LIMIT = 16;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 24;

   // clock, reset and block ports
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic [1:0]                           req_op = sfs_pkg::OP_TICK;
   logic [sfs_pkg::FRAME_W-1:0]          req_entry_index = '0;
   logic [sfs_pkg::DUR_W-1:0]            req_duration = '0;
   logic signed [sfs_pkg::FNUM_W-1:0]    req_frame_number = '0;
   logic                                 req_overwrite = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [sfs_pkg::FRAME_W-1:0]          rsp_frame_index;
   logic                                 rsp_completed;
   logic                                 rsp_active;
   logic [sfs_pkg::POS_W-1:0]            rsp_position_out;
   logic                                 csr_write_enable = 1'b0;
   logic [sfs_pkg::CSR_IDX_W-1:0]        csr_index = '0;
   logic [sfs_pkg::CSR_DATA_W-1:0]       csr_write_data = '0;

   // predicted sequencer state and register copies
   logic [sfs_pkg::DUR_W-1:0]   dur_table [sfs_pkg::FRAME_SLOTS];
   logic [sfs_pkg::POS_W-1:0]   pos_q;
   logic [sfs_pkg::FRAME_W-1:0] frame_q;
   logic                        done_q;
   logic                        run_q;
   logic [sfs_pkg::COUNT_W-1:0] cfg_count;
   logic                        cfg_loop;
   logic [sfs_pkg::SPEED_W-1:0] cfg_speed;

   sfs_pkg::rsp_type pending_states[$];
   int      mismatches  = 0;
   int      idle_cycles = 0;
   int      stall_left  = 0;
   bit      gaps_on     = 1'b1;
   bit      stalls_on   = 1'b1;

   sprite_frame_sequencer_top #(
      .MAX_ADVANCE(ADVANCE_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_duration     (req_duration),
      .req_frame_number (req_frame_number),
      .req_overwrite    (req_overwrite),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_completed    (rsp_completed),
      .rsp_active       (rsp_active),
      .rsp_position_out (rsp_position_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // frame count as the sequencer uses it
   function automatic int frames_in_use();
      if (cfg_count == 0) return 1;
      if (cfg_count > sfs_pkg::FRAME_SLOTS) return sfs_pkg::FRAME_SLOTS;
      return int'(cfg_count);
   endfunction

   // a zero duration lasts one lsb
   function automatic logic [sfs_pkg::POS_W-1:0] frame_length(
         logic [sfs_pkg::FRAME_W-1:0] f);
      if (dur_table[f] == '0) return sfs_pkg::POS_W'(1);
      return sfs_pkg::POS_W'(dur_table[f]);
   endfunction

   // one tick: add speed, then walk frames while the position covers them
   function automatic void walk_frames();
      int steps;
      int cnt;
      int next;
      steps = 0;
      cnt   = frames_in_use();
      if (!run_q) return;
      pos_q = pos_q + sfs_pkg::POS_W'(cfg_speed);
      while (steps < ADVANCE_LIMIT) begin
         if (pos_q < frame_length(frame_q)) break;
         pos_q = pos_q - frame_length(frame_q);
         next  = int'(frame_q) + 1;
         if (next >= cnt) begin
            done_q  = 1'b1;
            frame_q = cfg_loop ? '0 : sfs_pkg::FRAME_W'(cnt - 1);
         end else begin
            frame_q = sfs_pkg::FRAME_W'(next);
         end
         steps++;
      end
      // runaway tick: cap reached and still past the frame
      if (steps == ADVANCE_LIMIT && pos_q >= frame_length(frame_q)) pos_q = '0;
   endfunction

   // state after one request transaction
   function automatic sfs_pkg::rsp_type step_sequencer(sfs_pkg::op_type op,
                                              logic [sfs_pkg::FRAME_W-1:0] idx,
                                              logic [sfs_pkg::DUR_W-1:0] dur,
                                              logic signed [sfs_pkg::FNUM_W-1:0] fnum,
                                              logic ovw);
      sfs_pkg::rsp_type r;
      int      req;
      int      cnt;
      case (op)
         sfs_pkg::OP_TICK: begin
            walk_frames();
         end
         sfs_pkg::OP_WRITE_DUR: begin
            dur_table[idx] = dur;
         end
         sfs_pkg::OP_RESTART: begin
            if (ovw || !run_q) begin
               run_q   = 1'b1;
               frame_q = '0;
               pos_q   = '0;
               done_q  = 1'b0;
            end
         end
         default: begin
            cnt = frames_in_use();
            req = int'(fnum);
            if (req < 0) frame_q = '0;
            else if (req >= cnt) frame_q = sfs_pkg::FRAME_W'(cnt - 1);
            else frame_q = sfs_pkg::FRAME_W'(req);
            pos_q = '0;
         end
      endcase
      r.frame_index = frame_q;
      r.completed   = done_q;
      r.active      = run_q;
      r.position    = pos_q;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
   endtask

   // offer one request transaction, predict its result once accepted
   task automatic send_item(sfs_pkg::op_type op, logic [sfs_pkg::FRAME_W-1:0] idx,
                            logic [sfs_pkg::DUR_W-1:0] dur,
                            logic signed [sfs_pkg::FNUM_W-1:0] fnum, logic ovw);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_entry_index  <= idx;
      req_duration     <= dur;
      req_frame_number <= fnum;
      req_overwrite    <= ovw;
      do @(posedge clock); while (!req_ready);
      pending_states.push_back(step_sequencer(op, idx, dur, fnum, ovw));
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // drop valid, let every result drain and the engine settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, with the enable dropped again before the next
   task automatic write_csr(logic [sfs_pkg::CSR_IDX_W-1:0] idx,
                            logic [sfs_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sfs_pkg::CSR_FRAME_COUNT: begin
            cfg_count = data[sfs_pkg::COUNT_W-1:0];
         end
         sfs_pkg::CSR_LOOP_ENABLE: begin
            cfg_loop = data[0];
         end
         sfs_pkg::CSR_SPEED: begin
            cfg_speed = data[sfs_pkg::SPEED_W-1:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // tick and set-frame before any restart
   task automatic test_inactive();
      send_item(sfs_pkg::OP_TICK, 4'hF, 16'hFFFF, 16'sh7FFF, 1'b1);
      send_item(sfs_pkg::OP_SET_FRAME, 4'h0, 16'h0000, -16'sd32768, 1'b0);
      send_item(sfs_pkg::OP_SET_FRAME, 4'hA, 16'h5555, 16'sd32767, 1'b1);
   endtask

   // fill the whole table, zero and full-scale entries included
   task automatic test_table_load();
      logic [sfs_pkg::DUR_W-1:0] d;
      for (int i = 0; i < sfs_pkg::FRAME_SLOTS; i++) begin
         if (i == 0) d = 16'h0000;
         else if (i == sfs_pkg::FRAME_SLOTS - 1) d = 16'hFFFF;
         else d = sfs_pkg::DUR_W'(i * 96);
         send_item(sfs_pkg::OP_WRITE_DUR, sfs_pkg::FRAME_W'(i), d, -16'sd1, 1'b0);
      end
   endtask

   // restart from inactive, ignored restart, forced restart
   task automatic test_restart();
      send_item(sfs_pkg::OP_RESTART, 4'h3, 16'h00FF, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_TICK, 4'h0, 16'h0000, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_RESTART, 4'h0, 16'h0000, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_RESTART, 4'h0, 16'h0000, 16'sd0, 1'b1);
   endtask

   // clamping of the requested frame
   task automatic test_set_frame();
      wait_for_idle();
      write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd16);
      send_item(sfs_pkg::OP_SET_FRAME, 4'h0, 16'h0000, 16'sd32767, 1'b0);
      send_item(sfs_pkg::OP_SET_FRAME, 4'h0, 16'h0000, 16'sd7, 1'b0);
      send_item(sfs_pkg::OP_TICK, 4'h0, 16'h0000, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_SET_FRAME, 4'h0, 16'h0000, -16'sd1, 1'b0);
   endtask

   // near-zero durations with a huge speed hit the advance cap
   task automatic test_runaway();
      wait_for_idle();
      write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd2);
      write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd1);
      write_csr(sfs_pkg::CSR_SPEED, 16'hFFFF);
      send_item(sfs_pkg::OP_WRITE_DUR, 4'h0, 16'h0000, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_WRITE_DUR, 4'h1, 16'h0001, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_RESTART, 4'h0, 16'h0000, 16'sd0, 1'b1);
      send_item(sfs_pkg::OP_TICK, 4'h0, 16'h0000, 16'sd0, 1'b0);
   endtask

   // current frame left beyond a reduced frame count
   task automatic test_shrunk_count();
      wait_for_idle();
      write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd16);
      write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd0);
      send_item(sfs_pkg::OP_SET_FRAME, 4'h0, 16'h0000, 16'sd15, 1'b0);
      wait_for_idle();
      write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd4);
      send_item(sfs_pkg::OP_TICK, 4'h0, 16'h0000, 16'sd0, 1'b0);
      send_item(sfs_pkg::OP_TICK, 4'h0, 16'h0000, 16'sd0, 1'b0);
   endtask

   // random phases over several register settings
   task automatic test_random(int total);
      int                                per_phase;
      int                                r;
      int                                pace;
      sfs_pkg::op_type                   op;
      logic [sfs_pkg::DUR_W-1:0]         dur;
      logic signed [sfs_pkg::FNUM_W-1:0] fnum;
      per_phase = total / 9;
      for (int ph = 0; ph < 9; ph++) begin
         wait_for_idle();
         case (ph)
            0: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd16);
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd1);
               write_csr(sfs_pkg::CSR_SPEED, 16'd256);
            end
            1: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd1);
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd0);
               write_csr(sfs_pkg::CSR_SPEED, 16'd0);
            end
            2: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd0);
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd1);
               write_csr(sfs_pkg::CSR_SPEED, 16'hFFFF);
            end
            3: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd31);
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd0);
               write_csr(sfs_pkg::CSR_SPEED, 16'($urandom_range(0, 65535)));
            end
            4: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'd17);
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'd1);
               write_csr(sfs_pkg::CSR_SPEED, 16'($urandom_range(1, 300)));
            end
            default: begin
               write_csr(sfs_pkg::CSR_FRAME_COUNT, 16'($urandom_range(0, 31)));
               write_csr(sfs_pkg::CSR_LOOP_ENABLE, 16'($urandom_range(0, 1)));
               write_csr(sfs_pkg::CSR_SPEED, 16'($urandom_range(0, 2)) == 0 ?
                         16'($urandom_range(0, 65535)) : 16'($urandom_range(16, 1024)));
            end
         endcase
         send_item(sfs_pkg::OP_RESTART, 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
         for (int k = 0; k < per_phase; k++) begin
            // change pacing now and then, including stretches with no idling
            if (k % 40 == 0) begin
               pace      = $urandom_range(0, 3);
               gaps_on   = pace[0];
               stalls_on = pace[1];
            end
            r = $urandom_range(0, 99);
            if (r < 55) op = sfs_pkg::OP_TICK;
            else if (r < 70) op = sfs_pkg::OP_WRITE_DUR;
            else if (r < 80) op = sfs_pkg::OP_RESTART;
            else op = sfs_pkg::OP_SET_FRAME;
            case ($urandom_range(0, 3))
               0: begin
                  dur = 16'($urandom_range(0, 3));
               end
               1: begin
                  dur = 16'($urandom_range(64, 1024));
               end
               2: begin
                  dur = 16'($urandom_range(0, 65535));
               end
               default: begin
                  dur = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               end
            endcase
            case ($urandom_range(0, 2))
               0: begin
                  fnum = 16'($urandom_range(0, 20));
               end
               1: begin
                  fnum = -16'sd1 - 16'($urandom_range(0, 40));
               end
               default: begin
                  fnum = 16'($urandom_range(0, 65535));
               end
            endcase
            send_item(op, 4'($urandom_range(0, 15)), dur, fnum, 1'($urandom_range(0, 1)));
         end
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // result side: random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      sfs_pkg::rsp_type exp_state;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_states.size() == 0) begin
            report_mismatch("result transaction with no prediction waiting");
         end else begin
            exp_state = pending_states.pop_front();
            if (rsp_frame_index !== exp_state.frame_index)
               report_mismatch($sformatf("frame_index expected %0d actual %0d",
                                         exp_state.frame_index, rsp_frame_index));
            if (rsp_completed !== exp_state.completed)
               report_mismatch($sformatf("completed expected %0b actual %0b",
                                         exp_state.completed, rsp_completed));
            if (rsp_active !== exp_state.active)
               report_mismatch($sformatf("active expected %0b actual %0b",
                                         exp_state.active, rsp_active));
            if (rsp_position_out !== exp_state.position)
               report_mismatch($sformatf("position_out expected 0x%05h actual 0x%05h",
                                         exp_state.position, rsp_position_out));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      pos_q     = '0;
      frame_q   = '0;
      done_q    = 1'b0;
      run_q     = 1'b0;
      cfg_count = sfs_pkg::FRAME_COUNT_RESET;
      cfg_loop  = sfs_pkg::LOOP_RESET;
      cfg_speed = sfs_pkg::SPEED_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait_for_idle();
      test_inactive();
      test_table_load();
      test_restart();
      test_set_frame();
      test_runaway();
      test_shrunk_count();
      test_random(1150);
      wait_for_idle();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sprite_frame_sequencer_top.f =====
rtl/sfs_pkg.sv
rtl/sfs_dur_ram.sv
rtl/sfs_rsp_reg.sv
rtl/sfs_engine.sv
rtl/sprite_frame_sequencer_top.sv
bench/sprite_frame_sequencer_top_tb.sv
